// ===== design/spe_pkg.sv =====
// ----------------------------------------------------------------------------
// spe_pkg
// Shared types, constants and control store for the permutation enumerator.
// ----------------------------------------------------------------------------
package spe_pkg;

	localparam int MAX_ELEMENTS_DEF = 8;
	localparam int VALUE_BITS_DEF   = 16;
	localparam int IDX_BITS         = 3;
	localparam int CFG_BITS         = 4;
	localparam int UPC_BITS         = 5;

	localparam logic [CFG_BITS-1:0] N_RESET = 4'd8;

	typedef logic [UPC_BITS-1:0] upc_t;

	// control store addresses
	localparam upc_t UA_IDLE      = 5'd0;
	localparam upc_t UA_CHECK     = 5'd1;
	localparam upc_t UA_READ      = 5'd2;
	localparam upc_t UA_FWD_A     = 5'd3;
	localparam upc_t UA_FWD_B     = 5'd4;
	localparam upc_t UA_PUSH      = 5'd5;
	localparam upc_t UA_BACK_A    = 5'd6;
	localparam upc_t UA_BACK_B    = 5'd7;
	localparam upc_t UA_NEXT      = 5'd8;
	localparam upc_t UA_TOP_CHK   = 5'd9;
	localparam upc_t UA_POP       = 5'd10;
	localparam upc_t UA_SET_DONE  = 5'd11;
	localparam upc_t UA_EMIT_INIT = 5'd12;
	localparam upc_t UA_EMIT_RD   = 5'd13;
	localparam upc_t UA_EMIT      = 5'd14;
	localparam upc_t UA_EMIT_INC  = 5'd15;
	localparam upc_t UA_RETURN    = 5'd16;

	typedef enum logic [2:0] {
		MEM_NONE    = 3'd0,
		MEM_RD_SWAP = 3'd1,
		MEM_WR_A    = 3'd2,
		MEM_WR_B    = 3'd3,
		MEM_RD_EMIT = 3'd4
	} mem_op_t;

	typedef enum logic [2:0] {
		STK_NONE     = 3'd0,
		STK_COMPLETE = 3'd1,
		STK_PUSH     = 3'd2,
		STK_NEXT_SIB = 3'd3,
		STK_POP      = 3'd4,
		STK_SET_DONE = 3'd5
	} stk_op_t;

	typedef enum logic [3:0] {
		C_NEVER      = 4'd0,
		C_ALWAYS     = 4'd1,
		C_START      = 4'd2,
		C_DONE       = 4'd3,
		C_COMPLETED  = 4'd4,
		C_LAST_LEVEL = 4'd5,
		C_LAST_SIB   = 4'd6,
		C_TOP_ZERO   = 4'd7,
		C_OUT_FULL   = 4'd8,
		C_MORE       = 4'd9,
		C_WAIT       = 4'd10
	} cond_t;

	typedef struct packed {
		mem_op_t mem;
		stk_op_t stk;
		logic    idle;
		logic    k_clr;
		logic    k_inc;
		logic    emit;
	} dp_ctl_t;

	typedef struct packed {
		dp_ctl_t dp;
		cond_t   cond;
		upc_t    target;
	} ctl_word_t;

	typedef struct packed {
		logic start;
		logic done;
		logic completed;
		logic last_level;
		logic last_sib;
		logic top_zero;
		logic out_full;
		logic more;
	} stat_t;

	function automatic ctl_word_t ucode_rom(input upc_t addr);
		ctl_word_t w;
		w = '0;
		unique case (addr)
			UA_IDLE: begin
				w.dp.idle = 1'b1;
				w.cond    = C_WAIT;
				w.target  = UA_IDLE;
			end
			UA_CHECK: begin
				w.cond   = C_DONE;
				w.target = UA_EMIT_INIT;
			end
			UA_READ: begin
				w.dp.mem = MEM_RD_SWAP;
				w.cond   = C_COMPLETED;
				w.target = UA_BACK_A;
			end
			UA_FWD_A: begin
				w.dp.mem = MEM_WR_A;
			end
			UA_FWD_B: begin
				w.dp.mem = MEM_WR_B;
				w.dp.stk = STK_COMPLETE;
				w.cond   = C_LAST_LEVEL;
				w.target = UA_EMIT_INIT;
			end
			UA_PUSH: begin
				w.dp.stk = STK_PUSH;
				w.cond   = C_ALWAYS;
				w.target = UA_READ;
			end
			UA_BACK_A: begin
				w.dp.mem = MEM_WR_A;
			end
			UA_BACK_B: begin
				w.dp.mem = MEM_WR_B;
				w.cond   = C_LAST_SIB;
				w.target = UA_TOP_CHK;
			end
			UA_NEXT: begin
				w.dp.stk = STK_NEXT_SIB;
				w.cond   = C_ALWAYS;
				w.target = UA_READ;
			end
			UA_TOP_CHK: begin
				w.cond   = C_TOP_ZERO;
				w.target = UA_SET_DONE;
			end
			UA_POP: begin
				w.dp.stk = STK_POP;
				w.cond   = C_ALWAYS;
				w.target = UA_READ;
			end
			UA_SET_DONE: begin
				w.dp.stk = STK_SET_DONE;
			end
			UA_EMIT_INIT: begin
				w.dp.k_clr = 1'b1;
			end
			UA_EMIT_RD: begin
				w.dp.mem = MEM_RD_EMIT;
			end
			UA_EMIT: begin
				w.dp.emit = 1'b1;
				w.cond    = C_OUT_FULL;
				w.target  = UA_EMIT;
			end
			UA_EMIT_INC: begin
				w.dp.k_inc = 1'b1;
				w.cond     = C_MORE;
				w.target   = UA_EMIT_RD;
			end
			UA_RETURN: begin
				w.cond   = C_ALWAYS;
				w.target = UA_IDLE;
			end
			default: begin
				w.cond   = C_ALWAYS;
				w.target = UA_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== design/swap_permutation_enumerator.sv =====
// ----------------------------------------------------------------------------
// swap_permutation_enumerator
// Lists every ordering of a stored array by swap-based backtracking.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): op 0 writes load_value at load_index and
// restarts the listing; op 1 asks for the next ordering. A load request gives
// no result. A next request gives n_in_use results, clamped to 1..MAX_ELEMENTS,
// on the output channel (out_valid/out_ready), element 0 first, last set on the
// final one; once all orderings were given, values are zero and exhausted is
// set. A next request is dispatched and then runs forward steps that push, the
// forward step that completes an ordering, sibling steps, pops and the step
// that empties the stack, then emits each element. The first request runs
// forward steps only; for N of 2 or more a later one needs a pop, a sibling,
// a push and the closing forward step, plus a pop and a push for each further
// level it backs out of. Once exhausted a request goes straight to the emit
// steps.
// The config channel (cfg_valid/cfg_ready, data n_in_use) is taken only while
// the sequencer waits for a request; it also restarts the listing.
// Reset clears the store to zero, n_in_use to 8 and starts at the first level.
// A stalled receiver holds the sequencer on the emit step; the output
// register takes a new element in the same cycle that the held one is taken.
// ----------------------------------------------------------------------------
module swap_permutation_enumerator #(
	parameter int MAX_ELEMENTS = spe_pkg::MAX_ELEMENTS_DEF,
	parameter int VALUE_BITS   = spe_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         op,
	input  logic [spe_pkg::IDX_BITS-1:0] load_index,
	input  logic signed [VALUE_BITS-1:0] load_value,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [spe_pkg::CFG_BITS-1:0] n_in_use,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [spe_pkg::IDX_BITS-1:0] element_index,
	output logic signed [VALUE_BITS-1:0] element_value,
	output logic                         last,
	output logic                         exhausted
);
	import spe_pkg::*;

	dp_ctl_t ctl;
	stat_t   stat;

	spe_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	spe_datapath #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.VALUE_BITS   (VALUE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.load_index    (load_index),
		.load_value    (load_value),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.n_in_use      (n_in_use),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.element_index (element_index),
		.element_value (element_value),
		.last          (last),
		.exhausted     (exhausted)
	);

endmodule

// ===== design/spe_sequencer.sv =====
// ----------------------------------------------------------------------------
// spe_sequencer
// Step counter over the control store with conditional jumps.
// ----------------------------------------------------------------------------
module spe_sequencer (
	input  logic             clk,
	input  logic             arst_n,
	input  spe_pkg::stat_t   stat,
	output spe_pkg::dp_ctl_t ctl
);
	import spe_pkg::*;

	upc_t      upc_q;
	ctl_word_t word;
	logic      take;

	assign word = ucode_rom(upc_q);
	assign ctl  = word.dp;

	always_comb begin
		unique case (word.cond)
			C_NEVER:      take = 1'b0;
			C_ALWAYS:     take = 1'b1;
			C_START:      take = stat.start;
			C_DONE:       take = stat.done;
			C_COMPLETED:  take = stat.completed;
			C_LAST_LEVEL: take = stat.last_level;
			C_LAST_SIB:   take = stat.last_sib;
			C_TOP_ZERO:   take = stat.top_zero;
			C_OUT_FULL:   take = stat.out_full;
			C_MORE:       take = stat.more;
			C_WAIT:       take = ~stat.start;
			default:      take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UA_IDLE;
		end else if (take) begin
			upc_q <= word.target;
		end else begin
			upc_q <= upc_q + 1'b1;
		end
	end

endmodule

// ===== design/spe_datapath.sv =====
// ----------------------------------------------------------------------------
// spe_datapath
// Element store, node stack, emit counter and output register.
// ----------------------------------------------------------------------------
module spe_datapath #(
	parameter int MAX_ELEMENTS = spe_pkg::MAX_ELEMENTS_DEF,
	parameter int VALUE_BITS   = spe_pkg::VALUE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  spe_pkg::dp_ctl_t                 ctl,
	output spe_pkg::stat_t                   stat,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             op,
	input  logic [spe_pkg::IDX_BITS-1:0]     load_index,
	input  logic signed [VALUE_BITS-1:0]     load_value,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [spe_pkg::CFG_BITS-1:0]     n_in_use,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [spe_pkg::IDX_BITS-1:0]     element_index,
	output logic signed [VALUE_BITS-1:0]     element_value,
	output logic                             last,
	output logic                             exhausted
);
	import spe_pkg::*;

	localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int XW = CW + 1;

	logic signed [VALUE_BITS-1:0] mem [MAX_ELEMENTS];
	logic [MAX_ELEMENTS-1:0]      valid_q;
	logic signed [VALUE_BITS-1:0] rd_a_q, rd_b_q;
	logic                         rva_q, rvb_q;
	logic signed [VALUE_BITS-1:0] a_val, b_val;

	logic [IW-1:0]           node_swap_q [MAX_ELEMENTS];
	logic [MAX_ELEMENTS-1:0] node_done_q;
	logic [IW-1:0]           top_q, k_q;
	logic                    done_q;
	logic [CFG_BITS-1:0]     n_q;

	logic [CW-1:0] n_eff;
	logic [IW-1:0] s, t_inc, s_inc, ra_addr;
	logic [XW-1:0] t1, s1, k1, n_x;

	logic                         cfg_fire, in_fire, load_fire, restart;
	logic                         wr_en;
	logic [IW-1:0]                wr_addr;
	logic signed [VALUE_BITS-1:0] wr_data;
	logic                         out_full, emit_fire;

	logic [IDX_BITS-1:0]          idx_q;
	logic signed [VALUE_BITS-1:0] val_q;
	logic                         last_q, exh_q, out_valid_q;

	assign cfg_ready = ctl.idle;
	assign in_ready  = ctl.idle & ~cfg_valid;
	assign cfg_fire  = cfg_valid & cfg_ready;
	assign in_fire   = in_valid & in_ready;
	assign load_fire = in_fire & ~op;
	assign restart   = cfg_fire | load_fire;

	always_comb begin
		if (n_q == '0) begin
			n_eff = CW'(1);
		end else if (32'(n_q) > MAX_ELEMENTS) begin
			n_eff = CW'(MAX_ELEMENTS);
		end else begin
			n_eff = CW'(n_q);
		end
	end

	assign s     = node_swap_q[top_q];
	assign t_inc = top_q + 1'b1;
	assign s_inc = s + 1'b1;
	assign t1    = XW'(top_q) + 1'b1;
	assign s1    = XW'(s) + 1'b1;
	assign k1    = XW'(k_q) + 1'b1;
	assign n_x   = XW'(n_eff);

	assign a_val = rva_q ? rd_a_q : '0;
	assign b_val = rvb_q ? rd_b_q : '0;

	assign out_full  = out_valid_q & ~out_ready;
	assign emit_fire = ctl.emit & ~out_full;

	assign stat.start      = in_fire & op;
	assign stat.done       = done_q;
	assign stat.completed  = node_done_q[top_q];
	assign stat.last_level = t1 >= n_x;
	assign stat.last_sib   = s1 >= n_x;
	assign stat.top_zero   = top_q == '0;
	assign stat.out_full   = out_full;
	assign stat.more       = k1 < n_x;

	// single write port: loads, then the two halves of an exchange
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = top_q;
		wr_data = b_val;
		if (load_fire && (32'(load_index) < MAX_ELEMENTS)) begin
			wr_en   = 1'b1;
			wr_addr = IW'(load_index);
			wr_data = load_value;
		end
		unique case (ctl.mem)
			MEM_WR_A: begin
				wr_en   = 1'b1;
				wr_addr = top_q;
				wr_data = b_val;
			end
			MEM_WR_B: begin
				wr_en   = 1'b1;
				wr_addr = s;
				wr_data = a_val;
			end
			default: begin
			end
		endcase
	end

	assign ra_addr = (ctl.mem == MEM_RD_EMIT) ? k_q : top_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.mem == MEM_RD_SWAP || ctl.mem == MEM_RD_EMIT) begin
			rd_a_q <= mem[ra_addr];
			rva_q  <= valid_q[ra_addr];
			rd_b_q <= mem[s];
			rvb_q  <= valid_q[s];
		end
	end

	// invalid entries read as zero; exhaustion clears the whole store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.stk == STK_SET_DONE) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_ELEMENTS; i++) begin
				node_swap_q[i] <= IW'(i);
			end
			node_done_q <= '0;
			top_q       <= '0;
			done_q      <= 1'b0;
			n_q         <= N_RESET;
			k_q         <= '0;
		end else begin
			if (cfg_fire) begin
				n_q <= n_in_use;
			end
			if (restart) begin
				top_q          <= '0;
				node_swap_q[0] <= '0;
				node_done_q[0] <= 1'b0;
				done_q         <= 1'b0;
			end
			unique case (ctl.stk)
				STK_COMPLETE: begin
					node_done_q[top_q] <= 1'b1;
				end
				STK_PUSH: begin
					top_q              <= t_inc;
					node_swap_q[t_inc] <= t_inc;
					node_done_q[t_inc] <= 1'b0;
				end
				STK_NEXT_SIB: begin
					node_swap_q[top_q] <= s_inc;
					node_done_q[top_q] <= 1'b0;
				end
				STK_POP: begin
					top_q <= top_q - 1'b1;
				end
				STK_SET_DONE: begin
					done_q <= 1'b1;
				end
				default: begin
				end
			endcase
			if (ctl.k_clr) begin
				k_q <= '0;
			end else if (ctl.k_inc) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			idx_q  <= IDX_BITS'(k_q);
			val_q  <= done_q ? '0 : a_val;
			last_q <= k1 == n_x;
			exh_q  <= done_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign element_index = idx_q;
	assign element_value = val_q;
	assign last          = last_q;
	assign exhausted     = exh_q;

endmodule
